// ===== design/crcfr_pkg.sv =====
// ----------------------------------------------------------------------------
// crcfr_pkg: shared definitions for the CRC-checked frame receiver
// Field widths, CRC constants, configuration indexes and state types.
// ----------------------------------------------------------------------------
package crcfr_pkg;

  localparam int MAX_PAYLOAD_DEF = 64;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 7;
  localparam int CRC_W  = 16;
  localparam int IDLE_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

  localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'd60;
  localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'd62;
  localparam logic [IDLE_W-1:0] IDLE_TIMEOUT_RST = 16'd100;
  localparam logic [IDLE_W-1:0] IDLE_SAT         = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 2'd2;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_LEN_LO = 3'd1,
    PH_LEN_HI = 3'd2,
    PH_DATA   = 3'd3,
    PH_CRC_LO = 3'd4,
    PH_CRC_HI = 3'd5,
    PH_END    = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    CTL_IDLE = 2'd0,
    CTL_READ = 2'd1,
    CTL_SHOW = 2'd2
  } ctl_t;

  typedef struct packed {
    logic init;
    logic start;
  } crc_ctl_t;

endpackage

// ===== design/crcfr_crc_serial.sv =====
// ----------------------------------------------------------------------------
// crcfr_crc_serial: bit-serial CRC-16/CCITT-FALSE update
// Folds one byte into the running CRC, MSB first, one bit per cycle.
// ----------------------------------------------------------------------------
module crcfr_crc_serial (
  input  logic                         clk,
  input  logic                         rst_n,
  input  crcfr_pkg::crc_ctl_t          ctl,
  input  logic [crcfr_pkg::BYTE_W-1:0] data_in,
  output logic [crcfr_pkg::CRC_W-1:0]  crc,
  output logic                         busy
);

  logic [crcfr_pkg::CRC_W-1:0]  crc_r,  crc_nxt;
  logic [crcfr_pkg::BYTE_W-1:0] sh_r,   sh_nxt;
  logic [2:0]                   cnt_r,  cnt_nxt;
  logic                         busy_r, busy_nxt;
  logic                         fb;

  always_comb begin
    crc_nxt  = crc_r;
    sh_nxt   = sh_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    fb       = crc_r[crcfr_pkg::CRC_W-1] ^ sh_r[crcfr_pkg::BYTE_W-1];
    if (ctl.init) begin
      crc_nxt = crcfr_pkg::CRC_INIT;
    end else if (ctl.start) begin
      sh_nxt   = data_in;
      cnt_nxt  = 3'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      crc_nxt = {crc_r[crcfr_pkg::CRC_W-2:0], 1'b0} ^
                (fb ? crcfr_pkg::CRC_POLY : '0);
      sh_nxt  = {sh_r[crcfr_pkg::BYTE_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 3'd1;
      if (cnt_r == 3'd7) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r  <= crcfr_pkg::CRC_INIT;
      cnt_r  <= 3'd0;
      busy_r <= 1'b0;
    end else begin
      crc_r  <= crc_nxt;
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r <= sh_nxt;
  end

  assign crc  = crc_r;
  assign busy = busy_r;

endmodule

// ===== design/crcfr_store.sv =====
// ----------------------------------------------------------------------------
// crcfr_store: payload buffer
// One write port and one registered read port over the frame payload.
// ----------------------------------------------------------------------------
module crcfr_store #(
  parameter int DEPTH = crcfr_pkg::MAX_PAYLOAD_DEF,
  parameter int AW    = 6
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_addr,
  input  logic [crcfr_pkg::BYTE_W-1:0] wr_data,
  input  logic                         rd_en,
  input  logic [AW-1:0]                rd_addr,
  output logic [crcfr_pkg::BYTE_W-1:0] rd_data
);

  logic [crcfr_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [crcfr_pkg::BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/crc_checked_frame_receiver_top.sv =====
// ----------------------------------------------------------------------------
// crc_checked_frame_receiver_top: length-prefixed frame receiver, CRC checked
// Hunts for a start marker, reads length, payload, CRC and end marker, and
// replays the payload of each verified frame one word per result.
// ----------------------------------------------------------------------------
// Timing: a payload byte starts the bit-serial CRC unit, which folds one bit
// per cycle after the byte is accepted; no further input word is taken until
// the fold is done. Once the end marker of a good frame is taken, the payload
// is read back from the buffer one result word at a time: a registered memory
// read (READ), then the word is presented (SHOW) and held while the consumer
// stalls; no input word is taken until the last payload word has been
// delivered. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module crc_checked_frame_receiver_top #(
  parameter int MAX_PAYLOAD = crcfr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_operation,
  input  logic [crcfr_pkg::BYTE_W-1:0]     in_rx_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [crcfr_pkg::BYTE_W-1:0]     out_payload_byte,
  output logic [crcfr_pkg::LEN_W-1:0]      out_frame_length,
  output logic                             out_frame_last,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [crcfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [crcfr_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  // Configuration registers.
  logic [crcfr_pkg::BYTE_W-1:0] start_r, start_nxt;
  logic [crcfr_pkg::BYTE_W-1:0] end_r,   end_nxt;
  logic [crcfr_pkg::IDLE_W-1:0] tmo_r,   tmo_nxt;

  crcfr_pkg::phase_t phase_r, phase_nxt;
  crcfr_pkg::ctl_t   ctl_r,   ctl_nxt;

  logic [crcfr_pkg::BYTE_W-1:0] len_lo_r,  len_lo_nxt;
  logic [crcfr_pkg::LEN_W-1:0]  exp_len_r, exp_len_nxt;
  logic [crcfr_pkg::LEN_W-1:0]  cnt_r,     cnt_nxt;
  logic [crcfr_pkg::CRC_W-1:0]  rcrc_r,    rcrc_nxt;
  logic [crcfr_pkg::IDLE_W-1:0] idle_r,    idle_nxt;
  logic [crcfr_pkg::LEN_W-1:0]  emit_r,    emit_nxt;

  logic                         byte_fire, tick_fire, out_fire;
  logic [crcfr_pkg::CRC_W-1:0]  len_full;
  logic                         len_ok;
  logic [crcfr_pkg::LEN_W-1:0]  cnt_inc;
  logic                         data_done;
  logic                         frame_ok;
  logic [crcfr_pkg::IDLE_W-1:0] idle_inc;
  logic                         timeout_hit;
  logic                         emit_last;

  crcfr_pkg::crc_ctl_t          crc_ctl;
  logic [crcfr_pkg::CRC_W-1:0]  crc_val;
  logic                         crc_busy;
  logic                         wr_en, rd_en;
  logic [crcfr_pkg::BYTE_W-1:0] rd_data;

  assign byte_fire = in_valid && in_ready && (in_operation == crcfr_pkg::OP_BYTE);
  assign tick_fire = in_valid && in_ready && (in_operation == crcfr_pkg::OP_TICK);
  assign out_fire  = out_valid && out_ready;

  assign len_full    = {in_rx_byte, len_lo_r};
  assign len_ok      = (len_full != '0) &&
                       (len_full <= crcfr_pkg::CRC_W'(MAX_PAYLOAD));
  assign cnt_inc     = cnt_r + crcfr_pkg::LEN_W'(1);
  assign data_done   = cnt_inc >= exp_len_r;
  assign frame_ok    = (in_rx_byte == end_r) && (crc_val == rcrc_r);
  assign idle_inc    = (idle_r == crcfr_pkg::IDLE_SAT) ? idle_r :
                       idle_r + crcfr_pkg::IDLE_W'(1);
  assign timeout_hit = idle_inc > tmo_r;
  assign emit_last   = (emit_r + crcfr_pkg::LEN_W'(1)) == exp_len_r;

  // Configuration writes.
  always_comb begin
    start_nxt = start_r;
    end_nxt   = end_r;
    tmo_nxt   = tmo_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        crcfr_pkg::CFG_START_MARKER: start_nxt = cfg_data[crcfr_pkg::BYTE_W-1:0];
        crcfr_pkg::CFG_END_MARKER:   end_nxt   = cfg_data[crcfr_pkg::BYTE_W-1:0];
        crcfr_pkg::CFG_IDLE_TIMEOUT: tmo_nxt   = cfg_data;
        default: ;
      endcase
    end
  end

  // Frame phase: next state.
  always_comb begin
    phase_nxt = phase_r;
    if (tick_fire) begin
      if (phase_r != crcfr_pkg::PH_HUNT && timeout_hit) begin
        phase_nxt = crcfr_pkg::PH_HUNT;
      end
    end else if (byte_fire) begin
      unique case (phase_r)
        crcfr_pkg::PH_HUNT:   if (in_rx_byte == start_r) phase_nxt = crcfr_pkg::PH_LEN_LO;
        crcfr_pkg::PH_LEN_LO: phase_nxt = crcfr_pkg::PH_LEN_HI;
        crcfr_pkg::PH_LEN_HI: phase_nxt = len_ok ? crcfr_pkg::PH_DATA : crcfr_pkg::PH_HUNT;
        crcfr_pkg::PH_DATA:   if (data_done) phase_nxt = crcfr_pkg::PH_CRC_LO;
        crcfr_pkg::PH_CRC_LO: phase_nxt = crcfr_pkg::PH_CRC_HI;
        crcfr_pkg::PH_CRC_HI: phase_nxt = crcfr_pkg::PH_END;
        default:              phase_nxt = crcfr_pkg::PH_HUNT;
      endcase
    end
  end

  // Frame phase: datapath updates.
  always_comb begin
    len_lo_nxt    = len_lo_r;
    exp_len_nxt   = exp_len_r;
    cnt_nxt       = cnt_r;
    rcrc_nxt      = rcrc_r;
    idle_nxt      = idle_r;
    crc_ctl.init  = 1'b0;
    crc_ctl.start = 1'b0;
    wr_en         = 1'b0;
    if (tick_fire) begin
      idle_nxt = idle_inc;
    end else if (byte_fire) begin
      idle_nxt = '0;
      unique case (phase_r)
        crcfr_pkg::PH_LEN_LO: len_lo_nxt = in_rx_byte;
        crcfr_pkg::PH_LEN_HI: begin
          if (len_ok) begin
            exp_len_nxt  = len_full[crcfr_pkg::LEN_W-1:0];
            cnt_nxt      = '0;
            crc_ctl.init = 1'b1;
          end
        end
        crcfr_pkg::PH_DATA: begin
          wr_en         = 1'b1;
          crc_ctl.start = 1'b1;
          cnt_nxt       = cnt_inc;
        end
        crcfr_pkg::PH_CRC_LO: rcrc_nxt = {8'h00, in_rx_byte};
        crcfr_pkg::PH_CRC_HI: rcrc_nxt = {in_rx_byte, rcrc_r[crcfr_pkg::BYTE_W-1:0]};
        default: ;
      endcase
    end
  end

  // Result sequencer: next state.
  always_comb begin
    ctl_nxt  = ctl_r;
    emit_nxt = emit_r;
    unique case (ctl_r)
      crcfr_pkg::CTL_IDLE: begin
        if (byte_fire && phase_r == crcfr_pkg::PH_END && frame_ok) begin
          ctl_nxt  = crcfr_pkg::CTL_READ;
          emit_nxt = '0;
        end
      end
      crcfr_pkg::CTL_READ: ctl_nxt = crcfr_pkg::CTL_SHOW;
      crcfr_pkg::CTL_SHOW: begin
        if (out_fire) begin
          if (emit_last) begin
            ctl_nxt = crcfr_pkg::CTL_IDLE;
          end else begin
            ctl_nxt  = crcfr_pkg::CTL_READ;
            emit_nxt = emit_r + crcfr_pkg::LEN_W'(1);
          end
        end
      end
      default: ctl_nxt = crcfr_pkg::CTL_IDLE;
    endcase
  end

  // Result sequencer: outputs.
  always_comb begin
    in_ready  = (ctl_r == crcfr_pkg::CTL_IDLE) && !crc_busy;
    rd_en     = (ctl_r == crcfr_pkg::CTL_READ);
    out_valid = (ctl_r == crcfr_pkg::CTL_SHOW);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r   <= crcfr_pkg::START_MARKER_RST;
      end_r     <= crcfr_pkg::END_MARKER_RST;
      tmo_r     <= crcfr_pkg::IDLE_TIMEOUT_RST;
      phase_r   <= crcfr_pkg::PH_HUNT;
      ctl_r     <= crcfr_pkg::CTL_IDLE;
      len_lo_r  <= '0;
      exp_len_r <= '0;
      cnt_r     <= '0;
      rcrc_r    <= '0;
      idle_r    <= '0;
      emit_r    <= '0;
    end else begin
      start_r   <= start_nxt;
      end_r     <= end_nxt;
      tmo_r     <= tmo_nxt;
      phase_r   <= phase_nxt;
      ctl_r     <= ctl_nxt;
      len_lo_r  <= len_lo_nxt;
      exp_len_r <= exp_len_nxt;
      cnt_r     <= cnt_nxt;
      rcrc_r    <= rcrc_nxt;
      idle_r    <= idle_nxt;
      emit_r    <= emit_nxt;
    end
  end

  crcfr_crc_serial u_crc (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (crc_ctl),
    .data_in (in_rx_byte),
    .crc     (crc_val),
    .busy    (crc_busy)
  );

  crcfr_store #(
    .DEPTH (MAX_PAYLOAD),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt_r[AW-1:0]),
    .wr_data (in_rx_byte),
    .rd_en   (rd_en),
    .rd_addr (emit_r[AW-1:0]),
    .rd_data (rd_data)
  );

  assign cfg_ready        = 1'b1;
  assign out_payload_byte = rd_data;
  assign out_frame_length = exp_len_r;
  assign out_frame_last   = emit_last;

  // No input word may be taken while a frame is being replayed.
  a_no_input_during_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_r != crcfr_pkg::CTL_IDLE) |-> !in_ready)
    else $error("input accepted during payload replay");

  // A payload byte must not be followed by another word before its CRC fold ends.
  a_crc_fold_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (byte_fire && phase_r == crcfr_pkg::PH_DATA) |=> (crc_busy && !in_ready))
    else $error("CRC fold did not hold off the next word");

  // Taking the last word of a frame ends the replay.
  a_last_ends_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_frame_last) |=> (ctl_r == crcfr_pkg::CTL_IDLE))
    else $error("replay continued past the last word");

  // The stored length is always a legal payload length while payload is collected.
  a_len_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == crcfr_pkg::PH_DATA) |->
      (exp_len_r != '0 && exp_len_r <= crcfr_pkg::LEN_W'(MAX_PAYLOAD)))
    else $error("illegal expected length in payload phase");

endmodule
